>>> rtl/plc_pkg.sv
// plc_pkg: shared types and codes for the positional list store.
// Used by plc_cell and positional_list_store_top; no dependencies.

package plc_pkg;

   localparam int POS_W    = 5;
   localparam int HANDLE_W = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request kinds (code 3 is unused and answers with a range error)
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT,
      CELL_LOAD
   } cell_op_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                ins;
      logic                rem;
      logic [POS_W-1:0]    position;
      logic [HANDLE_W-1:0] handle;
   } cmd_type;

endpackage

>>> rtl/plc_cell.sv
// plc_cell: one list slot; shifts with its neighbours on insert/remove.
// Depends on plc_pkg.

module plc_cell #(
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  plc_pkg::cmd_type               cmd_in,
   input  logic [plc_pkg::HANDLE_W-1:0]   left_in,
   input  logic [plc_pkg::HANDLE_W-1:0]   right_in,
   output logic [plc_pkg::HANDLE_W-1:0]   data_out,
   output logic [plc_pkg::HANDLE_W-1:0]   rd_out
);
   import plc_pkg::*;

   logic [HANDLE_W-1:0] data_ff;
   logic [HANDLE_W-1:0] data_in;
   cell_op_type         op;
   int                  pos_i;

   always_comb begin
      pos_i = int'(cmd_in.position);
      op    = CELL_HOLD;
      if (cmd_in.ins) begin
         if (INDEX == pos_i)     op = CELL_LOAD;
         else if (INDEX > pos_i) op = CELL_FROM_LEFT;
      end else if (cmd_in.rem) begin
         if (INDEX >= pos_i)     op = CELL_FROM_RIGHT;
      end
   end

   always_comb begin
      unique case (op)
         CELL_HOLD:       data_in = data_ff;
         CELL_FROM_LEFT:  data_in = left_in;
         CELL_FROM_RIGHT: data_in = right_in;
         CELL_LOAD:       data_in = cmd_in.handle;
         default:         data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // masked read tap, ORed across the chain by the top level
   assign rd_out   = (INDEX == int'(cmd_in.position)) ? data_ff : '0;

endmodule

>>> rtl/positional_list_store_top.sv
// positional_list_store_top: bounded ordered list of handles held in a chain of cells.
// Depends on plc_pkg and plc_cell.
//
// Result: the result of a request is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while the held result is taken; every cell shifts in
// the same cycle, so the next request sees the updated count and cell contents.
// Reset: synchronous, active high; clears the count and the result valid flag.
// Cell contents are not reset; a cell is only read once it has been written.

module positional_list_store_top #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [4:0] position, [20:5] item_handle, [23:21] zero
   input  logic [1:0]  req_tuser,  // [1:0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [15:0] item_out, [20:16] entry_count, [23:21] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);
   import plc_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   // ---- request decode ----
   logic [KIND_W-1:0]   kind;
   logic [POS_W-1:0]    position;
   logic [HANDLE_W-1:0] item_handle;

   assign kind        = req_tuser;
   assign position    = req_tdata[POS_W-1:0];
   assign item_handle = req_tdata[POS_W +: HANDLE_W];

   // ---- control state ----
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_item_ff,   rsp_item_in;
   logic [COUNT_W-1:0]  rsp_count_ff,  rsp_count_in;

   logic          accept;
   logic [XW-1:0] pos_x, cnt_x, cnt_in_x;
   logic          pos_le_cnt, pos_lt_cnt, is_full;
   logic          ins_ok, rem_ok;
   cmd_type       cmd;

   // output register parts the two sides; accept while it is empty or the held result is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign pos_x      = XW'(position);
   assign cnt_x      = XW'(cnt_ff);
   assign pos_le_cnt = (pos_x <= cnt_x);
   assign pos_lt_cnt = (pos_x <  cnt_x);
   assign is_full    = (cnt_x == XW'(DEPTH));

   assign ins_ok = (kind == KIND_INSERT) && pos_le_cnt && !is_full;
   assign rem_ok = (kind == KIND_REMOVE) && pos_lt_cnt;

   always_comb begin
      cmd.ins      = accept && ins_ok;
      cmd.rem      = accept && rem_ok;
      cmd.position = position;
      cmd.handle   = item_handle;
   end

   // ---- the cell chain ----
   logic [HANDLE_W-1:0] cell_data [DEPTH];
   logic [HANDLE_W-1:0] cell_rd   [DEPTH];
   logic [HANDLE_W-1:0] rd_value;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [HANDLE_W-1:0] left_nb, right_nb;
      if (g == 0) begin : g_first
         assign left_nb = item_handle;      // never selected: cell 0 only loads
      end else begin : g_mid_l
         assign left_nb = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_nb = cell_data[g];    // vacated end slot, contents unused
      end else begin : g_mid_r
         assign right_nb = cell_data[g+1];
      end

      plc_cell #(
         .INDEX (g)
      ) u_cell (
         .clock    (clock),
         .cmd_in   (cmd),
         .left_in  (left_nb),
         .right_in (right_nb),
         .data_out (cell_data[g]),
         .rd_out   (cell_rd[g])
      );
   end

   // at most one cell matches the position; the rest tap out zero
   always_comb begin
      rd_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_value = rd_value | cell_rd[i];
      end
   end

   // ---- next count and result ----
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.ins)      cnt_in = cnt_ff + CW'(1);
      else if (cmd.rem) cnt_in = cnt_ff - CW'(1);
   end

   assign cnt_in_x = XW'(cnt_in);

   always_comb begin
      rsp_status_in = ST_RANGE;
      rsp_item_in   = '0;
      case (kind) inside
         KIND_INSERT: begin
            if (!pos_le_cnt)  rsp_status_in = ST_RANGE;
            else if (is_full) rsp_status_in = ST_FULL;
            else              rsp_status_in = ST_DONE;
         end
         KIND_REMOVE, KIND_READ: begin
            if (pos_lt_cnt) begin
               rsp_status_in = ST_DONE;
               rsp_item_in   = rd_value;
            end
         end
         default: begin
            rsp_status_in = ST_RANGE;
         end
      endcase
      rsp_count_in = cnt_in_x[COUNT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)          rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_item_ff   <= rsp_item_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_item_ff};

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      XW'(cnt_ff) <= XW'(DEPTH))
      else $error("entry count above depth");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> cnt_ff == CW'($past(cnt_ff) + CW'(1)))
      else $error("completed insert did not grow the count");

   a_rem_result: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |=> rsp_valid_ff && rsp_status_ff == ST_DONE
                  && XW'(rsp_count_ff) == XW'(cnt_ff))
      else $error("completed remove gave wrong result");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_DONE |-> rsp_item_ff == '0)
      else $error("error result carries a handle");

endmodule
